@@ sv/etf_pkg.sv @@
package etf_pkg;

	// image and number format
	localparam int IMG_WIDTH  = 1024;
	localparam int IMG_HEIGHT = 1024;
	localparam int FRAC_BITS  = 28;
	localparam int QW         = FRAC_BITS + 4;      // plane coordinate width
	localparam int DW         = 23;                 // pixel offset width
	localparam int OPW        = 38;                 // signed multiplier operand width
	localparam int MULW       = 32;                 // multiplier port width
	localparam int MW         = 2 * MULW;           // product width
	localparam int PW         = MW - FRAC_BITS + 1; // signed fixed-point product width
	localparam int ACCW       = 76;                 // wide product accumulator
	localparam int WW         = ACCW - FRAC_BITS + 1;
	localparam int SATW       = 54;                 // width ahead of saturation
	localparam int ADDR_W     = 5;
	localparam int CNT_W      = 10;

	localparam logic signed [DW-1:0] HALF_W = DW'(IMG_WIDTH / 2);
	localparam logic signed [DW-1:0] HALF_H = DW'(IMG_HEIGHT / 2);

	// fixed-point constants
	localparam logic signed [OPW-1:0] ONE_OP   = OPW'(longint'(1) << FRAC_BITS);
	localparam logic signed [OPW-1:0] QUART_OP = OPW'(longint'(1) << (FRAC_BITS - 2));
	localparam logic signed [PW:0]    ESC_LIM  = (PW + 1)'(longint'(4) << FRAC_BITS);
	localparam logic signed [PW:0]    BULB_LIM = (PW + 1)'(longint'(1) << (FRAC_BITS - 4));

	localparam logic signed [SATW-1:0] SAT_HI = {{(SATW - QW + 1){1'b0}}, {(QW - 1){1'b1}}};
	localparam logic signed [SATW-1:0] SAT_LO = {{(SATW - QW + 1){1'b1}}, {(QW - 1){1'b0}}};

	// fractal modes, code 3 runs as mandelbrot
	localparam logic [1:0] MODE_MANDEL = 2'd0;
	localparam logic [1:0] MODE_SHIP   = 2'd1;
	localparam logic [1:0] MODE_JULIA  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_PAN_X  = 3'd1;
	localparam logic [2:0] REG_PAN_Y  = 3'd2;
	localparam logic [2:0] REG_SCALEX = 3'd3;
	localparam logic [2:0] REG_SCALEY = 3'd4;
	localparam logic [2:0] REG_JRE    = 3'd5;
	localparam logic [2:0] REG_JIM    = 3'd6;
	localparam logic [2:0] REG_LIMIT  = 3'd7;

	localparam logic [30:0]      SCALE_RST = 31'd1048576;
	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(400);

	typedef enum logic [4:0] {
		S_IDLE,
		P_RE, P_IM, P_A, P_B,
		N_Y2, N_XP, N_XM, N_BL, N_Q, N_QX,
		N_W0, N_W1, N_W2, N_W3, N_A0, N_A1, N_CMP,
		I_X2, I_Y2, I_XY, I_WT, I_ESC, I_UPD,
		S_FIN
	} etf_state_t;

	// magnitude of a signed operand
	function automatic logic [OPW-1:0] mag_op(input logic signed [OPW-1:0] v);
		return v[OPW-1] ? OPW'(-v) : OPW'(v);
	endfunction

	// drop fraction bits of a product magnitude, then reapply the sign
	function automatic logic signed [PW-1:0] post_mul(input logic [MW-1:0] p, input logic neg);
		logic [PW-1:0] r;
		r = {1'b0, p[MW-1:FRAC_BITS]};
		return neg ? $signed(-r) : $signed(r);
	endfunction

	// clamp to the plane coordinate range
	function automatic logic signed [QW-1:0] sat_q(input logic signed [SATW-1:0] v);
		logic signed [QW-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[QW-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[QW-1:0];
		end else begin
			r = v[QW-1:0];
		end
		return r;
	endfunction

endpackage

@@ sv/escape_time_fractal.sv @@
// Escape-time fractal pixel engine (Mandelbrot, Burning Ship, Julia). One item is a pixel
// column and row; the result gives its iteration count, a bounded flag and an interior flag.
// All products go through one shared 32x32 multiplier with a registered operand stage and a
// registered product. In Mandelbrot mode the bulb and cardioid tests run before the
// iteration (the cardioid's wide product takes four multiplier passes), and pixels caught
// by either test finish as interior without iterating. in_ready is high only when no item
// is in work, so the block takes no new item before the result of the last one is loaded;
// a finished result waits in the output register.
// Registers are written through the APB port; the user must write them only while the
// block is idle, as the block itself does not enforce this.
module escape_time_fractal import etf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// pixel items
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [11:0]              pixel_col,
	input  logic [11:0]              pixel_row,
	// results
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [CNT_W-1:0]         iter_count,
	output logic                     bounded,
	output logic                     skipped_interior
);

	etf_state_t state_q, state_d;

	// configuration registers
	logic [1:0]               mode_q;
	logic signed [20:0]       pan_x_q, pan_y_q;
	logic [30:0]              scale_x_q, scale_y_q;
	logic signed [31:0]       jre_q, jim_q;
	logic [CNT_W-1:0]         limit_q;

	// working registers
	logic signed [DW-1:0]     dcol_q, drow_q;
	logic signed [QW-1:0]     x_q, y_q, cr_q, ci_q;
	logic signed [PW-1:0]     x2_q, y2_q, xy_q;
	logic signed [OPW-1:0]    q_q, qx_q;
	logic [ACCW-1:0]          acc_q;
	logic [CNT_W-1:0]         iter_q;
	logic                     bnd_q, skip_q;

	// shared multiplier pipe
	logic signed [OPW-1:0]    op_a, op_b;
	logic                     a_hi, b_hi;
	logic [OPW-1:0]           mag_a, mag_b;
	logic [MULW-1:0]          opa_s1, opb_s1;
	logic                     neg_s1, neg_s2;
	logic [MW-1:0]            prod_s2;

	// output register
	logic                     out_valid_q;
	logic [CNT_W-1:0]         cnt_out_q;
	logic                     bnd_out_q, skip_out_q;

	// derived values
	logic                     is_ship, is_julia, wr_en, in_acc, out_load;
	logic [2:0]               reg_idx;
	logic signed [PW-1:0]     mres, xy_abs;
	logic signed [SATW-1:0]   pm_mag, pm_in;
	logic signed [QW-1:0]     pmap, nx, ny;
	logic signed [OPW-1:0]    xp, xm;
	logic signed [PW:0]       sq_sum;
	logic [ACCW-FRAC_BITS-1:0] wmag;
	logic signed [WW-1:0]     w_val, card_lim;
	logic                     esc_hit, lim_hit, bulb_hit, card_hit;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:2];
	assign wr_en     = psel && penable && pwrite;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign is_ship   = (mode_q == MODE_SHIP);
	assign is_julia  = (mode_q == MODE_JULIA);

	assign out_valid        = out_valid_q;
	assign iter_count       = cnt_out_q;
	assign bounded          = bnd_out_q;
	assign skipped_interior = skip_out_q;

	// register read back
	always_comb begin
		case (reg_idx)
			REG_MODE:   prdata = 32'(mode_q);
			REG_PAN_X:  prdata = 32'($unsigned(pan_x_q));
			REG_PAN_Y:  prdata = 32'($unsigned(pan_y_q));
			REG_SCALEX: prdata = 32'(scale_x_q);
			REG_SCALEY: prdata = 32'(scale_y_q);
			REG_JRE:    prdata = $unsigned(jre_q);
			REG_JIM:    prdata = $unsigned(jim_q);
			REG_LIMIT:  prdata = 32'(limit_q);
			default:    prdata = '0;
		endcase
	end

	// post-processing of the product and the tests
	always_comb begin
		mres     = post_mul(prod_s2, neg_s2);
		xy_abs   = (is_ship && mres[PW-1]) ? -mres : mres;
		pm_mag   = $signed({1'b0, prod_s2[SATW-2:0]});
		pm_in    = neg_s2 ? -pm_mag : pm_mag;
		pmap     = sat_q(pm_in);
		nx       = sat_q(SATW'(x2_q) - SATW'(y2_q) + SATW'(cr_q));
		ny       = sat_q((SATW'(xy_q) <<< 1) + SATW'(ci_q));
		xp       = OPW'(cr_q) + ONE_OP;
		xm       = OPW'(cr_q) - QUART_OP;
		sq_sum   = (PW + 1)'(x2_q) + (PW + 1)'(y2_q);
		esc_hit  = sq_sum > ESC_LIM;
		lim_hit  = iter_q >= limit_q;
		bulb_hit = sq_sum < BULB_LIM;
		wmag     = acc_q[ACCW-1:FRAC_BITS];
		w_val    = qx_q[OPW-1] ? -$signed({1'b0, wmag}) : $signed({1'b0, wmag});
		card_lim = WW'(y2_q >>> 2);
		card_hit = w_val < card_lim;
	end

	// sequencer: next state and multiplier operand selection
	always_comb begin
		state_d = state_q;
		op_a    = '0;
		op_b    = '0;
		a_hi    = 1'b0;
		b_hi    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = P_RE;
			end
			P_RE: begin
				op_a    = OPW'(dcol_q);
				op_b    = OPW'($signed({1'b0, scale_x_q}));
				state_d = P_IM;
			end
			P_IM: begin
				op_a    = OPW'(drow_q);
				op_b    = OPW'($signed({1'b0, scale_y_q}));
				state_d = P_A;
			end
			P_A: state_d = P_B;
			P_B: begin
				state_d = (is_ship || is_julia) ? I_X2 : N_Y2;
			end
			N_Y2: begin
				op_a    = OPW'(ci_q);
				op_b    = OPW'(ci_q);
				state_d = N_XP;
			end
			N_XP: begin
				op_a    = xp;
				op_b    = xp;
				state_d = N_XM;
			end
			N_XM: begin
				op_a    = xm;
				op_b    = xm;
				state_d = N_BL;
			end
			N_BL: state_d = N_Q;
			N_Q: begin
				state_d = bulb_hit ? S_FIN : N_QX;
			end
			N_QX: state_d = N_W0;
			N_W0: begin
				op_a    = q_q;
				op_b    = qx_q;
				state_d = N_W1;
			end
			N_W1: begin
				op_a    = q_q;
				op_b    = qx_q;
				b_hi    = 1'b1;
				state_d = N_W2;
			end
			N_W2: begin
				op_a    = q_q;
				op_b    = qx_q;
				a_hi    = 1'b1;
				state_d = N_W3;
			end
			N_W3: begin
				op_a    = q_q;
				op_b    = qx_q;
				a_hi    = 1'b1;
				b_hi    = 1'b1;
				state_d = N_A0;
			end
			N_A0: state_d = N_A1;
			N_A1: state_d = N_CMP;
			N_CMP: begin
				state_d = card_hit ? S_FIN : I_X2;
			end
			I_X2: begin
				op_a    = OPW'(x_q);
				op_b    = OPW'(x_q);
				state_d = I_Y2;
			end
			I_Y2: begin
				op_a    = OPW'(y_q);
				op_b    = OPW'(y_q);
				state_d = I_XY;
			end
			I_XY: begin
				op_a    = OPW'(x_q);
				op_b    = OPW'(y_q);
				state_d = I_WT;
			end
			I_WT: state_d = I_ESC;
			I_ESC: begin
				state_d = (esc_hit || lim_hit) ? S_FIN : I_UPD;
			end
			I_UPD: state_d = I_X2;
			S_FIN: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign mag_a = mag_op(op_a);
	assign mag_b = mag_op(op_b);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, control flags and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_MANDEL;
			pan_x_q     <= '0;
			pan_y_q     <= '0;
			scale_x_q   <= SCALE_RST;
			scale_y_q   <= SCALE_RST;
			jre_q       <= '0;
			jim_q       <= '0;
			limit_q     <= LIMIT_RST;
			iter_q      <= '0;
			bnd_q       <= 1'b0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (reg_idx)
					REG_MODE:   mode_q    <= pwdata[1:0];
					REG_PAN_X:  pan_x_q   <= $signed(pwdata[20:0]);
					REG_PAN_Y:  pan_y_q   <= $signed(pwdata[20:0]);
					REG_SCALEX: scale_x_q <= pwdata[30:0];
					REG_SCALEY: scale_y_q <= pwdata[30:0];
					REG_JRE:    jre_q     <= $signed(pwdata);
					REG_JIM:    jim_q     <= $signed(pwdata);
					REG_LIMIT:  limit_q   <= pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			// per-item flags
			if (in_acc) begin
				iter_q <= '0;
				bnd_q  <= 1'b1;
				skip_q <= 1'b0;
			end else begin
				case (state_q)
					N_Q:   if (bulb_hit) skip_q <= 1'b1;
					N_CMP: if (card_hit) skip_q <= 1'b1;
					I_ESC: if (esc_hit) bnd_q <= 1'b0;
					I_UPD: iter_q <= iter_q + 1'b1;
					default: ;
				endcase
			end
			// result handshake
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dcol_q <= DW'($signed({1'b0, pixel_col})) + DW'(pan_x_q) - HALF_W;
			drow_q <= DW'($signed({1'b0, pixel_row})) + DW'(pan_y_q) - HALF_H;
		end
		// multiplier: operand stage, then product stage
		opa_s1  <= a_hi ? MULW'(mag_a[OPW-1:MULW]) : mag_a[MULW-1:0];
		opb_s1  <= b_hi ? MULW'(mag_b[OPW-1:MULW]) : mag_b[MULW-1:0];
		neg_s1  <= op_a[OPW-1] ^ op_b[OPW-1];
		prod_s2 <= opa_s1 * opb_s1;
		neg_s2  <= neg_s1;
		case (state_q)
			P_A: begin
				x_q  <= pmap;
				cr_q <= pmap;
			end
			P_B: begin
				if (is_julia) begin
					y_q  <= pmap;
					cr_q <= jre_q;
					ci_q <= jim_q;
				end else begin
					x_q  <= '0;
					y_q  <= '0;
					ci_q <= pmap;
				end
			end
			N_XM:  y2_q  <= mres;
			N_BL:  x2_q  <= mres;
			N_Q:   q_q   <= OPW'(mres) + OPW'(y2_q);
			N_QX:  qx_q  <= q_q + xm;
			N_W2:  acc_q <= ACCW'(prod_s2);
			N_W3:  acc_q <= acc_q + (ACCW'(prod_s2) << MULW);
			N_A0:  acc_q <= acc_q + (ACCW'(prod_s2) << MULW);
			N_A1:  acc_q <= acc_q + (ACCW'(prod_s2) << MW);
			I_XY:  x2_q  <= mres;
			I_WT:  y2_q  <= mres;
			I_ESC: xy_q  <= xy_abs;
			I_UPD: begin
				x_q <= nx;
				y_q <= ny;
			end
			default: ;
		endcase
		// result payload
		if (out_load) begin
			cnt_out_q  <= iter_q;
			bnd_out_q  <= bnd_q;
			skip_out_q <= skip_q;
		end
	end

	// an interior pixel reports no iterations and bounded
	a_skip_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && skip_out_q) |-> (cnt_out_q == '0 && bnd_out_q))
		else $error("interior result carries iterations or escape");

	// a bounded iterated pixel stopped exactly at the limit
	a_bnd_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bnd_out_q && !skip_out_q) |-> (cnt_out_q == limit_q))
		else $error("bounded result count differs from limit");

	// the iteration counter never runs past the limit while an item is in work
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (iter_q <= limit_q))
		else $error("iteration counter beyond limit");

	// interior shortcut only in mandelbrot mode
	a_skip_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && skip_out_q) |-> (!is_ship && !is_julia))
		else $error("interior shortcut outside mandelbrot mode");

	// an accepted item starts the coordinate mapping next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == P_RE))
		else $error("accepted item did not start");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import etf_pkg::*;

	localparam int  ITEMS       = 1100;
	localparam int  HOLD_CYCLES = 500;
	localparam longint ONE_FX   = longint'(1) << FRAC_BITS;
	localparam longint PLANE_HI = (longint'(1) << (FRAC_BITS + 3)) - 1;
	localparam longint PLANE_LO = -(longint'(1) << (FRAC_BITS + 3));

	typedef struct packed {
		logic [CNT_W-1:0] iters;
		logic             bnd;
		logic             skip;
	} pixel_result_t;

	// expected escape counts, with a private copy of the register file
	class escape_tracker;
		pixel_result_t pending_counts[$];
		logic [1:0]    mode;
		longint        pan_x, pan_y, scale_x, scale_y, c_re, c_im;
		int unsigned   limit;
		int            errors, n_interior, n_bounded, n_escaped;

		function new();
			mode = MODE_MANDEL;
			pan_x = 0;
			pan_y = 0;
			scale_x = longint'(SCALE_RST);
			scale_y = longint'(SCALE_RST);
			c_re = 0;
			c_im = 0;
			limit = 32'(LIMIT_RST);
			errors = 0;
			n_interior = 0;
			n_bounded = 0;
			n_escaped = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_MODE:   mode = v[1:0];
				REG_PAN_X:  pan_x = longint'($signed(v[20:0]));
				REG_PAN_Y:  pan_y = longint'($signed(v[20:0]));
				REG_SCALEX: scale_x = longint'(v[30:0]);
				REG_SCALEY: scale_y = longint'(v[30:0]);
				REG_JRE:    c_re = longint'($signed(v));
				REG_JIM:    c_im = longint'($signed(v));
				REG_LIMIT:  limit = 32'(v[CNT_W-1:0]);
				default: ;
			endcase
		endfunction

		// magnitude product, fraction dropped toward zero, clipped at 2^62
		function longint fx_mul(longint a, longint b);
			logic [63:0]  ua, ub;
			logic [127:0] prod;
			longint       r;
			ua = (a < 0) ? 64'(-a) : 64'(a);
			ub = (b < 0) ? 64'(-b) : 64'(b);
			prod = ({64'd0, ua} * {64'd0, ub}) >> FRAC_BITS;
			if (prod > (128'd1 << 62))
				prod = 128'd1 << 62;
			r = longint'(prod[63:0]);
			return ((a < 0) != (b < 0)) ? -r : r;
		endfunction

		function longint sat_plane(longint v);
			if (v > PLANE_HI)
				return PLANE_HI;
			if (v < PLANE_LO)
				return PLANE_LO;
			return v;
		endfunction

		// period-2 bulb, then main cardioid
		function bit in_main_bodies(longint cr, longint ci);
			longint y2, xp, xm, q;
			y2 = fx_mul(ci, ci);
			xp = cr + ONE_FX;
			xm = cr - (ONE_FX >>> 2);
			if (fx_mul(xp, xp) + y2 < (ONE_FX >>> 4))
				return 1'b1;
			q = fx_mul(xm, xm) + y2;
			return fx_mul(q, q + xm) < (y2 >>> 2);
		endfunction

		function pixel_result_t predict_escape(logic [11:0] col, logic [11:0] row);
			longint        plane_re, plane_im, x, y, cr, ci, x2, y2, xy, nx;
			int unsigned   i;
			bit            escaped, ship;
			pixel_result_t res;
			plane_re = sat_plane((longint'(col) + pan_x - IMG_WIDTH / 2) * scale_x);
			plane_im = sat_plane((longint'(row) + pan_y - IMG_HEIGHT / 2) * scale_y);
			i = 0;
			escaped = 1'b0;
			ship = (mode == MODE_SHIP);
			res = '0;
			if (mode == MODE_JULIA) begin
				x = plane_re;
				y = plane_im;
				cr = c_re;
				ci = c_im;
			end else begin
				x = 0;
				y = 0;
				cr = plane_re;
				ci = plane_im;
				if (!ship && in_main_bodies(cr, ci)) begin
					res.bnd = 1'b1;
					res.skip = 1'b1;
					return res;
				end
			end
			// escape test comes before the limit test
			while (1'b1) begin
				x2 = fx_mul(x, x);
				y2 = fx_mul(y, y);
				if (x2 + y2 > 4 * ONE_FX) begin
					escaped = 1'b1;
					break;
				end
				if (i >= limit)
					break;
				xy = fx_mul(x, y);
				if (ship && xy < 0)
					xy = -xy;
				nx = sat_plane(x2 - y2 + cr);
				y = sat_plane(2 * xy + ci);
				x = nx;
				i++;
			end
			res.iters = CNT_W'(i);
			res.bnd = !escaped;
			return res;
		endfunction

		function void note_pixel(logic [11:0] col, logic [11:0] row);
			pending_counts.push_back(predict_escape(col, row));
		endfunction

		function void check_count(logic [CNT_W-1:0] iters, logic bnd, logic skip);
			pixel_result_t exp_res;
			if (pending_counts.size() == 0) begin
				$error("result with no pixel pending: iter_count %0d bounded %0b", iters, bnd);
				errors++;
				return;
			end
			exp_res = pending_counts.pop_front();
			if (iters !== exp_res.iters) begin
				$error("iter_count: expected %0d, got %0d", exp_res.iters, iters);
				errors++;
			end
			if (bnd !== exp_res.bnd) begin
				$error("bounded: expected %0b, got %0b", exp_res.bnd, bnd);
				errors++;
			end
			if (skip !== exp_res.skip) begin
				$error("skipped_interior: expected %0b, got %0b", exp_res.skip, skip);
				errors++;
			end
			if (skip === 1'b1)
				n_interior++;
			else if (bnd === 1'b1)
				n_bounded++;
			else
				n_escaped++;
		endfunction

		function int pending();
			return pending_counts.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [11:0]       pixel_col = '0;
	logic [11:0]       pixel_row = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CNT_W-1:0]  iter_count;
	logic              bounded;
	logic              skipped_interior;

	escape_tracker board = new();
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit hold_results = 1'b0;

	escape_time_fractal dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pixel_col        (pixel_col),
		.pixel_row        (pixel_row),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.iter_count       (iter_count),
		.bounded          (bounded),
		.skipped_interior (skipped_interior)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(60_000_000);
		$display("Test completed with failures");
		$finish;
	end

	// setup and access cycle; the bus is left selected so writes can chain
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_reg(idx, value);
	endtask

	task automatic apply_setting(input logic [31:0] mode, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] jr, input logic [31:0] ji, input logic [31:0] lim);
		write_reg(REG_MODE, mode);
		write_reg(REG_PAN_X, px);
		write_reg(REG_PAN_Y, py);
		write_reg(REG_SCALEX, sx);
		write_reg(REG_SCALEY, sy);
		write_reg(REG_JRE, jr);
		write_reg(REG_JIM, ji);
		write_reg(REG_LIMIT, lim);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// offer one pixel item; valid stays up when there is no gap before the next
	task automatic offer_pixel(input logic [11:0] col, input logic [11:0] row);
		int gap;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_col <= col;
		pixel_row <= row;
		do @(posedge clk); while (!in_ready);
		board.note_pixel(col, row);
	endtask

	// stop offering and wait until every expected count has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// mostly inside the image, sometimes anywhere in the 12-bit range
	task automatic random_pixel(output logic [11:0] col, output logic [11:0] row);
		if ($urandom_range(0, 3) != 0) begin
			col = 12'($urandom_range(0, 1023));
			row = 12'($urandom_range(0, 1023));
		end else begin
			col = 12'($urandom);
			row = 12'($urandom);
		end
	endtask

	function automatic logic [31:0] random_pan();
		logic [31:0] r;
		r = $urandom;
		if ($urandom_range(0, 9) < 8)
			return 32'(int'($urandom_range(0, 400)) - 200);
		return {{11{r[20]}}, r[20:0]};
	endfunction

	function automatic logic [31:0] random_scale();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 8)
			return 32'($urandom_range(131072, 2097152));
		if (pick == 8)
			return 32'($urandom_range(0, 255));
		return $urandom;
	endfunction

	function automatic logic [31:0] random_julia();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return 32'(int'($urandom_range(0, 644245094)) - 322122547);
	endfunction

	function automatic logic [31:0] random_limit();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 2)
			return 32'd0;
		if (pick < 14)
			return 32'($urandom_range(1, 48));
		if (pick < 19)
			return 32'($urandom_range(49, 200));
		return 32'($urandom_range(201, 1023));
	endfunction

	// result side: random stalls, one long hold on request
	initial begin
		int gap;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = rx_idle ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_count(iter_count, bounded, skipped_interior);
		end
	end

	// stimulus
	initial begin
		logic [11:0] col, row;
		logic [31:0] lim;
		int          n, sent, phases;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: cardioid, bulb, corners, the cusp and the bulb joint
		offer_pixel(12'd512, 12'd512);
		offer_pixel(12'd256, 12'd512);
		offer_pixel(12'd0, 12'd0);
		offer_pixel(12'd4095, 12'd4095);
		offer_pixel(12'd0, 12'd4095);
		offer_pixel(12'd4095, 12'd0);
		offer_pixel(12'd576, 12'd512);
		offer_pixel(12'd320, 12'd512);
		settle();

		// burning ship at the largest limit
		apply_setting(32'(MODE_SHIP), 0, 0, 32'(SCALE_RST), 32'(SCALE_RST), 0, 0, 1023);
		offer_pixel(12'd256, 12'd512);
		offer_pixel(12'd320, 12'd600);
		settle();

		// julia with a classic constant
		apply_setting(32'(MODE_JULIA), 0, 0, 32'(SCALE_RST), 32'(SCALE_RST),
			32'(-214748365), 32'd41875931, 40);
		offer_pixel(12'd512, 12'd512);
		offer_pixel(12'd0, 12'd0);
		offer_pixel(12'd4095, 12'd4095);
		settle();

		// mode code three with a zero limit
		apply_setting(32'd3, 0, 0, 32'(SCALE_RST), 32'(SCALE_RST), 0, 0, 0);
		offer_pixel(12'd512, 12'd512);
		offer_pixel(12'd700, 12'd700);
		settle();

		// julia with a zero limit, start point outside and inside the disk
		apply_setting(32'(MODE_JULIA), 0, 0, 32'(SCALE_RST), 32'(SCALE_RST), 0, 0, 0);
		offer_pixel(12'd0, 12'd0);
		offer_pixel(12'd512, 12'd512);
		settle();

		// escape on the same step the limit is reached
		apply_setting(32'(MODE_MANDEL), 0, 0, 32'(SCALE_RST), 32'(SCALE_RST), 0, 0, 5);
		offer_pixel(12'd640, 12'd512);
		offer_pixel(12'd576, 12'd512);
		settle();

		// pan and scale extremes, saturated plane coordinates
		apply_setting(32'(MODE_MANDEL), 32'd1048575, 32'(-1048576), 32'h7fff_ffff,
			32'h7fff_ffff, 0, 0, 5);
		offer_pixel(12'd4095, 12'd0);
		offer_pixel(12'd0, 12'd4095);
		settle();

		// zero scale and julia constant extremes
		apply_setting(32'(MODE_JULIA), 32'(-1048576), 32'd1048575, 0, 0,
			32'h8000_0000, 32'h7fff_ffff, 3);
		offer_pixel(12'd1, 12'd1);
		offer_pixel(12'd4095, 12'd4095);
		settle();

		// random settings, each followed by a batch of random pixels
		sent = 0;
		phases = 0;
		while (sent < ITEMS) begin
			lim = random_limit();
			n = (lim > 200) ? 8 : $urandom_range(30, 70);
			tx_idle = (phases == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			rx_idle = $urandom_range(0, 3) != 0;
			apply_setting(32'($urandom_range(0, 3)), random_pan(), random_pan(),
				random_scale(), random_scale(), random_julia(), random_julia(), lim);
			// long output hold so the block backs up into its input
			if (phases == 1)
				hold_results = 1'b1;
			for (int k = 0; k < n; k++) begin
				if (phases == 2 && k == n / 2)
					settle();
				random_pixel(col, row);
				offer_pixel(col, row);
			end
			settle();
			sent += n;
			phases++;
		end

		// room for any stray result
		repeat (6 * board.limit + 64) @(posedge clk);
		$display("covered %0d random pixels over %0d random settings plus directed corners",
			sent, phases);
		$display("results: %0d interior skips, %0d bounded, %0d escaped",
			board.n_interior, board.n_bounded, board.n_escaped);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
